### sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the snapshot pacing scheduler
// Field widths, register indexes, sequencer states and the control words
// that pass between the sequencer, the datapath and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int TICK_W     = 32;  // elapsed ticks, tick deadline, max_ticks
  localparam int ITER_W     = 16;  // iteration, iteration budget, interval
  localparam int COUNT_W    = 16;  // snapshot count, target count
  localparam int ITER_DL_W  = 17;  // iteration deadline
  localparam int CFG_W      = 32;  // config write data
  localparam int CFG_IDX_W  = 2;   // config register index
  localparam int DIV_W      = 32;  // divider dividend / quotient
  localparam int DIVISOR_W  = 16;  // divider divisor / remainder

  localparam logic [TICK_W-1:0]  TICK_MAX        = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [TICK_W-1:0]  MAX_TICKS_RESET = TICK_MAX - TICK_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TICKS         = 2'd0,
    REG_ITER_BUDGET       = 2'd1,
    REG_TARGET_SNAPSHOTS  = 2'd2,
    REG_SNAPSHOT_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_QUERY   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_TICK,
    ST_TICK_WAIT,
    ST_ITER,
    ST_ITER_WAIT,
    ST_FINISH
  } state_t;

  // divider request: start pulse, half selects a 16-bit dividend in the top half
  typedef struct packed {
    logic start;
    logic half;
  } div_req_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic fire;
    logic tick_div;
    logic iter_div;
    logic div_done;
    logic out_free;
  } seq_stat_t;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic     in_ready;
    logic     eval_en;
    logic     tick_en;
    logic     tick_q_en;
    logic     iter_en;
    logic     iter_q_en;
    logic     out_load;
    div_req_t div;
  } seq_ctl_t;

endpackage

`default_nettype wire

### sv/sps_in_if.sv
// ----------------------------------------------------------------------------
// sps_in_if: query channel of the snapshot pacing scheduler
// Valid/ready channel carrying one operation word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_in_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [TICK_W-1:0] elapsed_ticks;
  logic [ITER_W-1:0] iteration;

  modport source (output valid, operation, elapsed_ticks, iteration, input ready);
  modport sink   (input valid, operation, elapsed_ticks, iteration, output ready);
endinterface

`default_nettype wire

### sv/sps_out_if.sv
// ----------------------------------------------------------------------------
// sps_out_if: result channel of the snapshot pacing scheduler
// Valid/ready channel carrying the take flag and the snapshot count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_out_if;
  import sps_pkg::*;

  logic               valid;
  logic               ready;
  logic               take_snapshot;
  logic [COUNT_W-1:0] snapshots_taken;

  modport source (output valid, take_snapshot, snapshots_taken, input ready);
  modport sink   (input valid, take_snapshot, snapshots_taken, output ready);
endinterface

`default_nettype wire

### sv/sps_div.sv
// ----------------------------------------------------------------------------
// sps_div: shared radix-2 restoring divider
// One quotient bit per cycle. Full mode runs 32 steps on a 32-bit dividend;
// half mode runs 16 steps on a dividend placed in the upper half.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_div (
  input  logic                         clk,
  input  logic                         rst,
  input  sps_pkg::div_req_t            req,
  input  logic [sps_pkg::DIV_W-1:0]     dividend,
  input  logic [sps_pkg::DIVISOR_W-1:0] divisor,
  output logic                         done,
  output logic [sps_pkg::DIV_W-1:0]     quotient
);
  import sps_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(DIV_W / 2 - 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIV_W-1:0]     dvd;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   trial;
  logic                 qbit;

  assign shifted  = {rem, dvd[DIV_W-1]};
  assign trial    = shifted - {1'b0, divisor};
  assign qbit     = (shifted >= {1'b0, divisor});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= dividend;
      cnt <= req.half ? CNT_HALF : CNT_FULL;
    end else if (busy) begin
      rem <= qbit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      dvd <= {dvd[DIV_W-2:0], qbit};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

### sv/sps_seq.sv
// ----------------------------------------------------------------------------
// sps_seq: sequencer of the snapshot pacing scheduler
// Steps one word through evaluate, then (if it fires) tick and iteration
// deadlines and result hand-off, starting the shared divider where needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_seq (
  input  logic               clk,
  input  logic               rst,
  input  sps_pkg::seq_stat_t stat,
  output sps_pkg::seq_ctl_t  ctl
);
  import sps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (stat.in_valid) state_next = ST_EVAL;
      ST_EVAL:      state_next = stat.fire ? ST_TICK : ST_FINISH;
      ST_TICK:      state_next = stat.tick_div ? ST_TICK_WAIT : ST_ITER;
      ST_TICK_WAIT: if (stat.div_done) state_next = ST_ITER;
      ST_ITER:      state_next = stat.iter_div ? ST_ITER_WAIT : ST_FINISH;
      ST_ITER_WAIT: if (stat.div_done) state_next = ST_FINISH;
      ST_FINISH:    if (stat.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
      end
      ST_EVAL: begin
        ctl.eval_en = 1'b1;
      end
      ST_TICK: begin
        ctl.tick_en   = 1'b1;
        ctl.div.start = stat.tick_div;
      end
      ST_TICK_WAIT: begin
        ctl.tick_q_en = stat.div_done;
      end
      ST_ITER: begin
        ctl.iter_en   = 1'b1;
        ctl.div.start = stat.iter_div;
        ctl.div.half  = 1'b1;
      end
      ST_ITER_WAIT: begin
        ctl.iter_q_en = stat.div_done;
      end
      ST_FINISH: begin
        ctl.out_load = stat.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/snapshot_pacing_scheduler.sv
// ----------------------------------------------------------------------------
// snapshot_pacing_scheduler: decides when a run should take a snapshot
// Each query word brings elapsed ticks and the iteration number and returns
// a take flag and the running snapshot count.
//
// Channels: in_ch (operation, elapsed_ticks, iteration) and out_ch
// (take_snapshot, snapshots_taken), both valid/ready; one result word per
// input word, in order. Config is a write-only port (cfg_we, cfg_index,
// cfg_wdata), written by the user only while the block is idle; not enforced.
// Path: a query that does not fire goes from evaluate straight to the result
// step; a restart or firing query also sets the tick and iteration deadlines.
// A word may need two divisions on one shared radix-2 divider, 32 steps for
// the tick deadline and 16 for the iteration deadline.
// One word at a time: in_ch.ready is high only while idle, so a new word is
// accepted only after the last result has been loaded for output.
// The result sits in an output register, so the next word is accepted while
// it waits; if out_ch stalls, the following result holds in the last step.
// Reset: count and deadlines clear to zero, config takes its reset values,
// no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module snapshot_pacing_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sps_pkg::CFG_W-1:0]     cfg_wdata,
  sps_in_if.sink                       in_ch,
  sps_out_if.source                    out_ch
);
  import sps_pkg::*;

  // config
  logic [TICK_W-1:0]  max_ticks;
  logic [ITER_W-1:0]  iteration_budget;
  logic [COUNT_W-1:0] target_snapshots;
  logic [ITER_W-1:0]  snapshot_interval;

  // state
  logic [COUNT_W-1:0]   taken_count;
  logic [TICK_W-1:0]    next_tick_deadline;
  logic [ITER_DL_W-1:0] next_iteration_deadline;

  // per-word working registers
  op_t                op_r;
  logic [TICK_W-1:0]  now_r;
  logic [ITER_W-1:0]  iter_r;
  logic               take_r;
  logic [COUNT_W-1:0] left_r;
  logic               tgt_done_r;

  logic               out_valid;
  logic               out_take;
  logic [COUNT_W-1:0] out_count;

  seq_stat_t stat;
  seq_ctl_t  ctl;

  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [DIV_W-1:0]   div_dividend;

  logic               modes_on;
  logic               fire;
  logic [COUNT_W-1:0] count_new;
  logic [ITER_W-1:0]  span;
  logic               tick_div;
  logic               iter_div;
  logic [TICK_W-1:0]    tick_direct;
  logic [ITER_DL_W-1:0] iter_direct;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ticks         <= MAX_TICKS_RESET;
      iteration_budget  <= '0;
      target_snapshots  <= '0;
      snapshot_interval <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_TICKS:         max_ticks         <= cfg_wdata[TICK_W-1:0];
        REG_ITER_BUDGET:       iteration_budget  <= cfg_wdata[ITER_W-1:0];
        REG_TARGET_SNAPSHOTS:  target_snapshots  <= cfg_wdata[COUNT_W-1:0];
        REG_SNAPSHOT_INTERVAL: snapshot_interval <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // evaluate step
  assign modes_on = (target_snapshots != '0) || (snapshot_interval != '0);
  assign fire     = (op_r == OP_RESTART) ||
                    (modes_on && ((now_r >= next_tick_deadline) ||
                                  ({1'b0, iter_r} >= next_iteration_deadline)));

  always_comb begin
    if (op_r == OP_RESTART) begin
      count_new = '0;
    end else if (fire && taken_count != COUNT_MAX) begin
      count_new = taken_count + COUNT_W'(1);
    end else begin
      count_new = taken_count;
    end
  end

  // tick deadline step
  assign tick_div    = !tgt_done_r && (now_r < max_ticks);
  assign tick_direct = tgt_done_r ? ((max_ticks == TICK_MAX) ? TICK_MAX
                                                              : max_ticks + TICK_W'(1))
                                  : now_r;

  // iteration deadline step
  assign span     = iteration_budget - iter_r;
  assign iter_div = (target_snapshots != '0) && !tgt_done_r &&
                    (iter_r < iteration_budget) && (left_r < span);

  always_comb begin
    if (target_snapshots == '0) begin
      iter_direct = {1'b0, iter_r} + {1'b0, snapshot_interval};
    end else if (tgt_done_r) begin
      iter_direct = {1'b0, iteration_budget} + ITER_DL_W'(1);
    end else begin
      iter_direct = {1'b0, iter_r} + ITER_DL_W'(1);
    end
  end

  assign div_dividend = ctl.div.half ? {span, {(DIV_W - ITER_W){1'b0}}}
                                     : (max_ticks - now_r);

  always_ff @(posedge clk) begin
    if (in_ch.valid && ctl.in_ready) begin
      op_r   <= op_t'(in_ch.operation);
      // restart works as at time and iteration zero
      now_r  <= (in_ch.operation == OP_RESTART) ? '0 : in_ch.elapsed_ticks;
      iter_r <= (in_ch.operation == OP_RESTART) ? '0 : in_ch.iteration;
    end
    if (ctl.eval_en) begin
      take_r     <= fire && (op_r == OP_QUERY);
      left_r     <= target_snapshots - count_new;
      tgt_done_r <= (target_snapshots <= count_new);
    end
    if (ctl.out_load) begin
      out_take  <= take_r;
      out_count <= taken_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken_count             <= '0;
      next_tick_deadline      <= '0;
      next_iteration_deadline <= '0;
      out_valid               <= 1'b0;
    end else begin
      if (ctl.eval_en) begin
        taken_count <= count_new;
      end
      if (ctl.tick_en && !tick_div) begin
        next_tick_deadline <= tick_direct;
      end else if (ctl.tick_q_en) begin
        next_tick_deadline <= now_r + div_q;
      end
      if (ctl.iter_en && !iter_div) begin
        next_iteration_deadline <= iter_direct;
      end else if (ctl.iter_q_en) begin
        next_iteration_deadline <= {1'b0, iter_r} + {1'b0, div_q[ITER_W-1:0]};
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.in_valid = in_ch.valid;
  assign stat.fire     = fire;
  assign stat.tick_div = tick_div;
  assign stat.iter_div = iter_div;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ch.ready;

  sps_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  sps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (ctl.div),
    .dividend (div_dividend),
    .divisor  (left_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ch.ready            = ctl.in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.take_snapshot   = out_take;
  assign out_ch.snapshots_taken = out_count;

endmodule

`default_nettype wire

### sv/sps_chk.sv
// ----------------------------------------------------------------------------
// sps_chk: port-level checks of the snapshot pacing scheduler
// Watches the channels for one-at-a-time acceptance, held results and
// consistent take results, and for no pending result after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       take,
  input logic [sps_pkg::COUNT_W-1:0] count
);

  // one word in flight: no accept on the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sps_chk: word accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(take) && $stable(count)))
    else $error("sps_chk: stalled result changed");

  a_take_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && take) |-> (count != '0))
    else $error("sps_chk: snapshot taken with zero count");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("sps_chk: result pending after reset");

endmodule

bind snapshot_pacing_scheduler sps_chk u_sps_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .take      (out_ch.take_snapshot),
  .count     (out_ch.snapshots_taken)
);

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for snapshot_pacing_scheduler
// Drives restart and query words through the input channel with random gaps,
// stalls the result channel at random, and checks every result word against
// a pacing tracker that keeps its own copy of the count, the deadlines and
// the config. Runs through directed cases, random config phases with paced
// runs, and a short back-to-back run where every query fires.
// ----------------------------------------------------------------------------
module testbench;
  import sps_pkg::*;

  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int     FIRE_RUN    = 20;

  typedef struct {
    logic               take;
    logic [COUNT_W-1:0] count;
  } snap_verdict_t;

  // Pacing tracker: predicts take flag and count for each accepted word
  class snapshot_tracker;
    logic [TICK_W-1:0]    max_ticks;
    logic [ITER_W-1:0]    max_iters;
    logic [COUNT_W-1:0]   target;
    logic [ITER_W-1:0]    interval;
    logic [COUNT_W-1:0]   taken;
    logic [TICK_W-1:0]    tick_dl;
    logic [ITER_DL_W-1:0] iter_dl;
    snap_verdict_t        due_verdicts[$];
    int                   mismatches;

    function new();
      max_ticks   = MAX_TICKS_RESET;
      max_iters   = '0;
      target      = '0;
      interval    = '0;
      taken       = '0;
      tick_dl     = '0;
      iter_dl     = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_MAX_TICKS:         max_ticks = v;
        REG_ITER_BUDGET:       max_iters = v[ITER_W-1:0];
        REG_TARGET_SNAPSHOTS:  target    = v[COUNT_W-1:0];
        REG_SNAPSHOT_INTERVAL: interval  = v[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [TICK_W-1:0] next_tick(logic [TICK_W-1:0] now);
      logic [COUNT_W-1:0] left;
      if (target <= taken)
        return (max_ticks == TICK_MAX) ? TICK_MAX : max_ticks + TICK_W'(1);
      left = target - taken;
      if (now >= max_ticks)
        return now;
      return now + (max_ticks - now) / left;
    endfunction

    function logic [ITER_DL_W-1:0] next_iter(logic [ITER_W-1:0] it);
      logic [COUNT_W-1:0] left;
      logic [ITER_W-1:0]  span;
      if (target == '0)
        return ITER_DL_W'(it) + ITER_DL_W'(interval);
      if (target <= taken)
        return ITER_DL_W'(max_iters) + ITER_DL_W'(1);
      left = target - taken;
      // no iterations left: step by one
      if (it >= max_iters)
        return ITER_DL_W'(it) + ITER_DL_W'(1);
      span = max_iters - it;
      if (left >= span)
        return ITER_DL_W'(it) + ITER_DL_W'(1);
      return ITER_DL_W'(it) + ITER_DL_W'(span / left);
    endfunction

    function void note_word(op_t op, logic [TICK_W-1:0] now, logic [ITER_W-1:0] it);
      snap_verdict_t v;
      v.take = 1'b0;
      if (op == OP_RESTART) begin
        taken   = '0;
        tick_dl = next_tick('0);
        iter_dl = next_iter('0);
      end else if (target != '0 || interval != '0) begin
        if (now >= tick_dl || {1'b0, it} >= iter_dl) begin
          v.take = 1'b1;
          if (taken != COUNT_MAX)
            taken = taken + COUNT_W'(1);
          tick_dl = next_tick(now);
          iter_dl = next_iter(it);
        end
      end
      v.count = taken;
      due_verdicts.insert(due_verdicts.size(), v);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(logic take, logic [COUNT_W-1:0] count);
      snap_verdict_t v;
      if (due_verdicts.size() == 0) begin
        flag($sformatf("result word with none expected (take=%0b count=%0d)", take, count));
        return;
      end
      v = due_verdicts.pop_front();
      if (take !== v.take)
        flag($sformatf("take_snapshot exp %0b got %0b", v.take, take));
      if (count !== v.count)
        flag($sformatf("snapshots_taken exp %0d got %0d", v.count, count));
    endfunction

    function int pending();
      return due_verdicts.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  longint               cycles = 0;
  bit                   tx_idle = 1'b1;
  bit                   rx_idle = 1'b1;
  int                   stall_left = 0;

  snapshot_tracker tracker = new();

  sps_in_if  in_ch();
  sps_out_if out_ch();

  snapshot_pacing_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TICK_W-1:0] pick_tick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TICK_W'(1);
      2:       return TICK_W'($urandom_range(2, 5000));
      3:       return $urandom;
      4:       return MAX_TICKS_RESET;
      default: return TICK_MAX;
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'($urandom_range(2, 20));
      3:       return 16'($urandom_range(21, 2000));
      4:       return 16'($urandom);
      default: return 16'hFFFF;
    endcase
  endfunction

  // result side: random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (rx_idle && $urandom_range(0, 99) < 25) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.take_snapshot, out_ch.snapshots_taken);
  end

  task automatic send_word(op_t op, logic [TICK_W-1:0] now, logic [ITER_W-1:0] it);
    int g;
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.elapsed_ticks <= now;
    in_ch.iteration     <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_word(op, now, it);
    g = tx_idle ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drain all results, then let the block settle before config writes
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [TICK_W-1:0] mt, logic [15:0] mi, logic [15:0] tg,
                              logic [15:0] iv);
    cfg_reg_t         regs [4];
    logic [CFG_W-1:0] vals [4];
    regs = '{REG_MAX_TICKS, REG_ITER_BUDGET, REG_TARGET_SNAPSHOTS, REG_SNAPSHOT_INTERVAL};
    vals = '{mt, CFG_W'(mi), CFG_W'(tg), CFG_W'(iv)};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
      tracker.write_reg(regs[k], vals[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly paced runs: restart, then rising time and iteration; some noise
  task automatic run_paced(int n, logic [TICK_W-1:0] mt, logic [15:0] mi, logic [15:0] tg,
                           logic [15:0] iv);
    logic [TICK_W:0]   now;
    logic [ITER_W:0]   it;
    logic [TICK_W-1:0] step_t;
    logic [ITER_W-1:0] step_i;
    int                r;
    settle();
    write_config(mt, mi, tg, iv);
    step_t = mt / 24 + TICK_W'(1);
    step_i = ((mi > iv) ? mi : iv) / 16 + ITER_W'(1);
    now = '0;
    it  = '0;
    send_word(OP_RESTART, $urandom, 16'($urandom));
    for (int k = 1; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        now = '0;
        it  = '0;
        send_word(OP_RESTART, $urandom, 16'($urandom));
      end else if (r < 14) begin
        send_word(op_t'($urandom_range(0, 1)), $urandom, 16'($urandom));
      end else begin
        now = now + (TICK_W+1)'($urandom_range(0, step_t));
        it  = it + (ITER_W+1)'($urandom_range(0, step_i));
        if (now[TICK_W]) now = {1'b0, TICK_MAX};
        if (it[ITER_W])  it  = {1'b0, {ITER_W{1'b1}}};
        send_word(OP_QUERY, now[TICK_W-1:0], it[ITER_W-1:0]);
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_MAX_TICKS;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_QUERY;
    in_ch.elapsed_ticks = '0;
    in_ch.iteration     = '0;
    out_ch.ready        = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset config: both modes off, nothing fires
    send_word(OP_QUERY, TICK_MAX, 16'hFFFF);
    send_word(OP_QUERY, '0, '0);

    // interval mode, no tick limit; first query fires on the zero deadlines
    settle();
    write_config(TICK_MAX, 16'd0, 16'd0, 16'd5);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_QUERY, 32'd100, 16'd4);
    send_word(OP_QUERY, '0, 16'd5);
    send_word(OP_QUERY, TICK_MAX, '0);
    send_word(OP_RESTART, TICK_MAX, 16'hFFFF);
    send_word(OP_QUERY, '0, 16'd4);

    // widest interval: iteration deadline past 16 bits
    settle();
    write_config(MAX_TICKS_RESET, 16'hFFFF, 16'd0, 16'hFFFF);
    send_word(OP_RESTART, '0, '0);
    send_word(OP_QUERY, '0, 16'hFFFF);
    send_word(OP_QUERY, MAX_TICKS_RESET, 16'hFFFF);
    send_word(OP_QUERY, TICK_MAX, '0);

    // target mode with interval also set; run past the target
    settle();
    write_config(32'd1000, 16'd100, 16'd3, 16'd7);
    send_word(OP_RESTART, '0, '0);
    send_word(OP_QUERY, 32'd10, 16'd33);
    send_word(OP_QUERY, 32'd600, 16'd40);
    send_word(OP_QUERY, 32'd1200, 16'd50);
    send_word(OP_QUERY, 32'd1000, 16'd101);
    send_word(OP_QUERY, 32'd5, 16'd99);
    send_word(OP_RESTART, '0, '0);
    send_word(OP_QUERY, '0, 16'd99);
    send_word(OP_QUERY, '0, 16'd150);

    // random config phases, extremes first
    run_paced(100, TICK_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_paced(100, '0, 16'd0, 16'd1, 16'd0);
    for (int p = 0; p < 11; p++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = tx_idle;
      if ($urandom_range(0, 1) == 0)
        run_paced(95, pick_tick_limit(), pick_count(), 16'($urandom_range(1, 12)),
                  pick_count());
      else
        run_paced(95, pick_tick_limit(), pick_count(), pick_count(), pick_count());
    end

    // every query fires, words back to back
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    settle();
    write_config('0, 16'($urandom), 16'd0, 16'd1);
    send_word(OP_RESTART, '0, '0);
    for (int k = 0; k < FIRE_RUN; k++)
      send_word(OP_QUERY, $urandom | TICK_W'(1), 16'($urandom));

    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
